/* rtl/smce_pkg.sv */
package smce_pkg;

  localparam int MAX_CLASSES = 1024;
  localparam int IDX_W       = 10;
  localparam int COUNT_W     = 11;
  localparam int SCORE_W     = 16;
  localparam int PROB_W      = 16;
  localparam int SUM_W       = 27;
  localparam int LOSS_W      = 24;
  localparam int GRAD_W      = 25;
  localparam int WEIGHT_W    = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd256;
  localparam logic [16:0]         LOG2E_Q16    = 17'd94548;
  localparam logic [15:0]         LN2_Q16      = 16'd45426;
  localparam logic [LOSS_W-1:0]   LOSS_MAX     = 24'hFFFFFF;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_READOUT = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  function automatic logic [16:0] pow2_tab(input logic [4:0] i);
    case (i)
      5'd0:    pow2_tab = 17'd65536;
      5'd1:    pow2_tab = 17'd62757;
      5'd2:    pow2_tab = 17'd60097;
      5'd3:    pow2_tab = 17'd57549;
      5'd4:    pow2_tab = 17'd55109;
      5'd5:    pow2_tab = 17'd52773;
      5'd6:    pow2_tab = 17'd50535;
      5'd7:    pow2_tab = 17'd48393;
      5'd8:    pow2_tab = 17'd46341;
      5'd9:    pow2_tab = 17'd44376;
      5'd10:   pow2_tab = 17'd42495;
      5'd11:   pow2_tab = 17'd40693;
      5'd12:   pow2_tab = 17'd38968;
      5'd13:   pow2_tab = 17'd37316;
      5'd14:   pow2_tab = 17'd35734;
      5'd15:   pow2_tab = 17'd34219;
      default: pow2_tab = 17'd32768;
    endcase
  endfunction

  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    case (i)
      5'd0:    log2_tab = 17'd0;
      5'd1:    log2_tab = 17'd5732;
      5'd2:    log2_tab = 17'd11136;
      5'd3:    log2_tab = 17'd16248;
      5'd4:    log2_tab = 17'd21098;
      5'd5:    log2_tab = 17'd25711;
      5'd6:    log2_tab = 17'd30109;
      5'd7:    log2_tab = 17'd34312;
      5'd8:    log2_tab = 17'd38336;
      5'd9:    log2_tab = 17'd42196;
      5'd10:   log2_tab = 17'd45904;
      5'd11:   log2_tab = 17'd49472;
      5'd12:   log2_tab = 17'd52911;
      5'd13:   log2_tab = 17'd56229;
      5'd14:   log2_tab = 17'd59434;
      5'd15:   log2_tab = 17'd62534;
      default: log2_tab = 17'd65536;
    endcase
  endfunction

endpackage

/* rtl/softmax_cross_entropy_unit.sv */
// Softmax with cross-entropy loss, argmax and per-class gradient readout.
// Input channel (in_valid/in_ready) carries load and readout transactions.
// Loads write one class score each; the load with last set also brings
// the label and starts the compute. The compute makes two passes over the
// score memory: the first streams one class per cycle through the exp
// pipeline, the second runs each class, one at a time, through the exp
// pipeline and a 17-step restoring divider; the loss arithmetic in states
// S_L1 to S_L5 then forms the summary. A readout goes through the
// probability memory read and the gradient multiplier (S_RD1, S_RD2);
// an out-of-range readout goes straight to the output state.
// Results leave through an output register (out_valid/out_ready); the
// next transaction is accepted while a result waits, and a stalled
// receiver holds the block only when a second result is ready.
// loss_weight is written through cfg_we/cfg_wdata; the user writes it at
// an idle time only, and the block itself does not enforce this. Reset
// clears counts, the running maximum and the held label, and sets
// loss_weight to 1.0; both memories stay unwritten and need no clearing.
module softmax_cross_entropy_unit import smce_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [WEIGHT_W-1:0]       cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic signed [SCORE_W-1:0] score,
  input  logic                      last,
  input  logic [IDX_W-1:0]          label,
  input  logic                      label_valid,
  input  logic [IDX_W-1:0]          class_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      kind,
  output logic [1:0]                status,
  output logic [LOSS_W-1:0]         loss,
  output logic                      loss_valid,
  output logic [IDX_W-1:0]          best_class,
  output logic [PROB_W-1:0]         best_prob,
  output logic [PROB_W-1:0]         class_prob,
  output logic signed [GRAD_W-1:0]  gradient
);

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_P2, S_L1, S_L2, S_L3, S_L4, S_L5, S_RD1, S_RD2, S_OUT
  } state_t;

  state_t state;

  logic [SCORE_W-1:0]        score_mem [MAX_CLASSES];
  logic [PROB_W-1:0]         prob_mem  [MAX_CLASSES];
  logic signed [SCORE_W-1:0] score_q;
  logic [PROB_W-1:0]         prob_q;

  logic [WEIGHT_W-1:0]       loss_weight;
  logic [COUNT_W-1:0]        class_count;
  logic [COUNT_W-1:0]        ready_count;
  logic signed [SCORE_W-1:0] running_max;
  logic [SUM_W-1:0]          exp_sum;
  logic [IDX_W-1:0]          held_label;
  logic                      held_label_valid;
  logic                      overflow;

  logic [COUNT_W-1:0] rd_idx;
  logic [COUNT_W-1:0] wr_idx;
  logic               busy;
  logic               a_v, b_v, c_v, e_v;
  logic [32:0]        b_xf;
  logic [16:0]        c_base;
  logic [28:0]        c_prod;
  logic [4:0]         c_n;
  logic               c_zero;
  logic [16:0]        e_val;

  logic               div_active;
  logic [4:0]         div_cnt;
  logic [SUM_W-1:0]   div_rem;
  logic [16:0]        div_dq;

  logic [PROB_W-1:0]  label_p;
  logic [IDX_W-1:0]   best_idx;
  logic [PROB_W-1:0]  best_p;

  logic [3:0]         l_k;
  logic [3:0]         l_i;
  logic [11:0]        l_r;
  logic               l_zero;
  logic [20:0]        l_nl;
  logic [36:0]        l_t;
  logic [52:0]        l_v;

  logic                     rd_hot;
  logic signed [33:0]       g_v;

  logic                     res_kind;
  logic [1:0]               res_status;
  logic [LOSS_W-1:0]        res_loss;
  logic                     res_loss_valid;
  logic [IDX_W-1:0]         res_best_class;
  logic [PROB_W-1:0]        res_best_prob;
  logic [PROB_W-1:0]        res_class_prob;
  logic signed [GRAD_W-1:0] res_gradient;

  logic in_acc;
  logic issue;
  logic prob_we;
  logic score_we;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign issue    = (rd_idx < class_count) &&
                    ((state == S_P1) || (state == S_P2 && !busy));
  assign prob_we  = (state == S_P2) && div_active && (div_cnt == 5'd0);
  assign score_we = in_acc && (opcode == OP_LOAD) &&
                    (class_count < COUNT_W'(MAX_CLASSES));

  // exp pipeline arithmetic
  logic [SCORE_W:0]  d_full;
  logic [24:0]       x_w;
  logic [3:0]        xi;
  logic [16:0]       x_base;
  logic [16:0]       x_dl;
  logic [16:0]       m_w;
  logic [17:0]       rnd_w;
  logic [17:0]       e_sh;

  always_comb begin
    d_full = {running_max[SCORE_W-1], running_max} - {score_q[SCORE_W-1], score_q};
    x_w    = b_xf[32:8];
    xi     = x_w[15:12];
    x_base = pow2_tab({1'b0, xi});
    x_dl   = x_base - pow2_tab({1'b0, xi} + 5'd1);
    m_w    = c_base - 17'((c_prod + 29'd2048) >> 12);
    rnd_w  = (c_n == 5'd0) ? 18'd0 : (18'd1 << (c_n - 5'd1));
    e_sh   = ({1'b0, m_w} + rnd_w) >> c_n;
  end

  // divider step
  logic [SUM_W:0]  div_rem2;
  logic            div_ge;
  logic [32:0]     div_num;
  logic [PROB_W-1:0] p_sat;

  always_comb begin
    div_rem2 = {div_rem, div_dq[16]};
    div_ge   = div_rem2 >= {1'b0, exp_sum};
    div_num  = {e_val, 16'd0} + 33'(exp_sum >> 1);
    p_sat    = div_dq[16] ? {PROB_W{1'b1}} : div_dq[PROB_W-1:0];
  end

  // loss arithmetic
  logic [3:0]  k_w;
  logic [16:0] norm_w;
  logic [16:0] lb_w;
  logic [16:0] ldl_w;
  logic [20:0] l2_w;
  logic [20:0] vr_w;

  always_comb begin
    k_w = 4'd0;
    for (int j = 0; j < PROB_W; j++) begin
      if (label_p[j]) k_w = 4'(j);
    end
    norm_w = {1'b0, label_p} << (5'd16 - {1'b0, k_w});
    lb_w   = log2_tab({1'b0, l_i});
    ldl_w  = log2_tab({1'b0, l_i} + 5'd1) - lb_w;
    l2_w   = {1'b0, l_k, 16'd0} + {4'd0, lb_w} +
             21'((29'(ldl_w) * 29'(l_r) + 29'd2048) >> 12);
    vr_w   = 21'((l_v + 53'h80000000) >> 32);
  end

  // gradient arithmetic
  logic signed [17:0] g_diff;
  logic [33:0]        g_mag;
  logic [25:0]        g_rm;
  logic signed [26:0] g_s;

  always_comb begin
    g_diff = $signed({2'b00, prob_q}) - (rd_hot ? 18'sh10000 : 18'sh0);
    g_mag  = g_v[33] ? 34'(-g_v) : 34'(g_v);
    g_rm   = 26'((g_mag + 34'd128) >> 8);
    g_s    = g_v[33] ? -$signed({1'b0, g_rm}) : $signed({1'b0, g_rm});
  end

  always_ff @(posedge clk) begin
    if (score_we) begin
      score_mem[class_count[IDX_W-1:0]] <= score;
    end
    score_q <= score_mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (prob_we) begin
      prob_mem[wr_idx[IDX_W-1:0]] <= p_sat;
    end
    if (in_acc) begin
      prob_q <= prob_mem[class_index];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    b_xf   <= 33'(d_full[SCORE_W-1:0]) * 33'(LOG2E_Q16);
    c_base <= x_base;
    c_prod <= 29'(x_dl) * 29'(x_w[11:0]);
    c_zero <= x_w[24:16] >= 9'd17;
    c_n    <= x_w[20:16];
    e_val  <= c_zero ? 17'd0 : e_sh[16:0];
    l_k    <= k_w;
    l_i    <= norm_w[15:12];
    l_r    <= norm_w[11:0];
    l_zero <= (label_p == '0);
    l_nl   <= (l2_w >= 21'h100000) ? 21'd0 : 21'h100000 - l2_w;
    l_t    <= 37'(l_nl) * 37'(LN2_Q16);
    l_v    <= 53'(l_t) * 53'(loss_weight);
    g_v    <= 34'($signed({1'b0, loss_weight})) * 34'(g_diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      loss_weight      <= WEIGHT_RESET;
      class_count      <= '0;
      ready_count      <= '0;
      running_max      <= {1'b1, {(SCORE_W-1){1'b0}}};
      exp_sum          <= '0;
      held_label       <= '0;
      held_label_valid <= 1'b0;
      overflow         <= 1'b0;
      rd_idx           <= '0;
      wr_idx           <= '0;
      busy             <= 1'b0;
      a_v              <= 1'b0;
      b_v              <= 1'b0;
      c_v              <= 1'b0;
      e_v              <= 1'b0;
      div_active       <= 1'b0;
      div_cnt          <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        loss_weight <= cfg_wdata;
      end

      a_v <= issue;
      b_v <= a_v;
      c_v <= b_v;
      e_v <= c_v;
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end

      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (opcode == OP_LOAD) begin
              if (class_count < COUNT_W'(MAX_CLASSES)) begin
                class_count <= class_count + 1'b1;
                if (score > running_max) running_max <= score;
              end else begin
                overflow <= 1'b1;
              end
              if (last) begin
                held_label       <= label;
                held_label_valid <= label_valid;
                exp_sum          <= '0;
                rd_idx           <= '0;
                state            <= S_P1;
              end
            end else begin
              rd_hot <= held_label_valid && (class_index == held_label);
              if ({1'b0, class_index} >= ready_count) begin
                res_kind       <= KIND_READOUT;
                res_status     <= ST_RANGE;
                res_loss       <= '0;
                res_loss_valid <= 1'b0;
                res_best_class <= '0;
                res_best_prob  <= '0;
                res_class_prob <= '0;
                res_gradient   <= '0;
                state          <= S_OUT;
              end else begin
                state <= S_RD1;
              end
            end
          end
        end
        S_P1: begin
          if (e_v) begin
            exp_sum <= exp_sum + SUM_W'(e_val);
          end
          if (rd_idx == class_count && !a_v && !b_v && !c_v && !e_v) begin
            rd_idx  <= '0;
            wr_idx  <= '0;
            busy    <= 1'b0;
            label_p <= '0;
            best_idx <= '0;
            best_p  <= '0;
            state   <= S_P2;
          end
        end
        S_P2: begin
          if (issue) begin
            busy <= 1'b1;
          end
          if (e_v) begin
            div_rem    <= SUM_W'(div_num[32:17]);
            div_dq     <= div_num[16:0];
            div_cnt    <= 5'd17;
            div_active <= 1'b1;
          end else if (div_active) begin
            if (div_cnt != 5'd0) begin
              div_rem <= div_ge ? SUM_W'(div_rem2 - {1'b0, exp_sum}) : div_rem2[SUM_W-1:0];
              div_dq  <= {div_dq[15:0], div_ge};
              div_cnt <= div_cnt - 1'b1;
            end else begin
              div_active <= 1'b0;
              busy       <= 1'b0;
              wr_idx     <= wr_idx + 1'b1;
              if (wr_idx == '0 || p_sat > best_p) begin
                best_p   <= p_sat;
                best_idx <= wr_idx[IDX_W-1:0];
              end
              if (wr_idx == {1'b0, held_label}) begin
                label_p <= p_sat;
              end
              if (wr_idx + 1'b1 == class_count) begin
                state <= S_L1;
              end
            end
          end
        end
        S_L1: state <= S_L2;
        S_L2: state <= S_L3;
        S_L3: state <= S_L4;
        S_L4: state <= S_L5;
        S_L5: begin
          res_kind       <= KIND_SUMMARY;
          res_status     <= overflow ? ST_OVERFLOW : ST_OK;
          res_loss_valid <= held_label_valid;
          if (!held_label_valid) begin
            res_loss <= '0;
          end else if (l_zero || vr_w > 21'(LOSS_MAX)) begin
            res_loss <= LOSS_MAX;
          end else begin
            res_loss <= LOSS_W'(vr_w);
          end
          res_best_class <= best_idx;
          res_best_prob  <= best_p;
          res_class_prob <= '0;
          res_gradient   <= '0;
          ready_count    <= class_count;
          class_count    <= '0;
          running_max    <= {1'b1, {(SCORE_W-1){1'b0}}};
          overflow       <= 1'b0;
          rd_idx         <= '0;
          state          <= S_OUT;
        end
        S_RD1: state <= S_RD2;
        S_RD2: begin
          res_kind       <= KIND_READOUT;
          res_status     <= ST_OK;
          res_loss       <= '0;
          res_loss_valid <= 1'b0;
          res_best_class <= '0;
          res_best_prob  <= '0;
          res_class_prob <= prob_q;
          if (g_s > 27'sd16777215) begin
            res_gradient <= 25'sh0FFFFFF;
          end else if (g_s < -27'sd16777216) begin
            res_gradient <= 25'sh1000000;
          end else begin
            res_gradient <= GRAD_W'(g_s);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            kind       <= res_kind;
            status     <= res_status;
            loss       <= res_loss;
            loss_valid <= res_loss_valid;
            best_class <= res_best_class;
            best_prob  <= res_best_prob;
            class_prob <= res_class_prob;
            gradient   <= res_gradient;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_div_in_p2: assert property (@(posedge clk) disable iff (rst)
    div_active |-> state == S_P2)
    else $error("divider active outside second pass");

  a_sum_acc: assert property (@(posedge clk) disable iff (rst)
    (state == S_P1 && e_v) |=> exp_sum == $past(exp_sum) + SUM_W'($past(e_val)))
    else $error("exp sum accumulation mismatch");

  a_prob_wr_range: assert property (@(posedge clk) disable iff (rst)
    prob_we |-> wr_idx < class_count)
    else $error("probability write beyond class count");

  a_summary_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_L5 |=> class_count == '0 && !overflow)
    else $error("sample state not cleared after summary");
`endif

endmodule

/* tb/tb.sv */
module tb;
  import smce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [16:0] POW2_LUT [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
    44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
  localparam logic [16:0] LOG2_LUT [17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

  typedef struct packed {
    logic                     kind;
    logic [1:0]               status;
    logic [LOSS_W-1:0]        loss;
    logic                     loss_valid;
    logic [IDX_W-1:0]         best_class;
    logic [PROB_W-1:0]        best_prob;
    logic [PROB_W-1:0]        class_prob;
    logic signed [GRAD_W-1:0] gradient;
  } smce_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [WEIGHT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_LOAD;
  logic signed [SCORE_W-1:0] score = '0;
  logic last = 1'b0;
  logic [IDX_W-1:0] label = '0;
  logic label_valid = 1'b0;
  logic [IDX_W-1:0] class_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [1:0] status;
  logic [LOSS_W-1:0] loss;
  logic loss_valid;
  logic [IDX_W-1:0] best_class;
  logic [PROB_W-1:0] best_prob;
  logic [PROB_W-1:0] class_prob;
  logic signed [GRAD_W-1:0] gradient;

  softmax_cross_entropy_unit u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .score(score),
    .last(last), .label(label), .label_valid(label_valid),
    .class_index(class_index), .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .status(status), .loss(loss), .loss_valid(loss_valid),
    .best_class(best_class), .best_prob(best_prob), .class_prob(class_prob),
    .gradient(gradient)
  );

  // predictor state
  logic signed [SCORE_W-1:0] score_mem [MAX_CLASSES];
  logic [PROB_W-1:0] prob_mem [MAX_CLASSES];
  int unsigned loaded_cnt = 0;
  int unsigned ready_cnt = 0;
  int signed peak_score = -32768;
  logic [IDX_W-1:0] label_q = '0;
  logic label_valid_q = 1'b0;
  logic overflow_q = 1'b0;
  logic [WEIGHT_W-1:0] weight_q = WEIGHT_RESET;

  smce_result_t expected_q [$];
  int unsigned mismatches = 0;
  int unsigned sent_items = 0;
  int unsigned cycles = 0;
  int unsigned rx_wait = 0;
  bit rx_calm = 0;
  bit tx_calm = 0;
  bit hold_req = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] exp_weight(input int unsigned d);
    logic [63:0] x, n, f, i, r, m;
    x = (64'(d) * 64'(LOG2E_Q16)) >> 8;
    n = x >> 16;
    f = x & 64'hFFFF;
    i = f >> 12;
    r = f & 64'hFFF;
    if (n >= 17) return 0;
    m = POW2_LUT[i] - (((64'(POW2_LUT[i] - POW2_LUT[i+1])) * r + 2048) >> 12);
    if (n == 0) return m;
    return (m + (64'd1 << (n - 1))) >> n;
  endfunction

  function automatic logic [LOSS_W-1:0] neg_log_loss(input logic [63:0] p,
                                                     input logic [63:0] w);
    int k;
    logic [63:0] norm, frac, i, r, l2, nl, v;
    k = 0;
    if (p == 0) return LOSS_MAX;
    while (k < 63 && (p >> (k + 1)) != 0) k++;
    norm = (k <= 16) ? (p << (16 - k)) : (p >> (k - 16));
    frac = (norm - 65536) & 64'hFFFF;
    i = frac >> 12;
    r = frac & 64'hFFF;
    l2 = 64'(k) * 65536 + LOG2_LUT[i] +
         (((64'(LOG2_LUT[i+1] - LOG2_LUT[i])) * r + 2048) >> 12);
    nl = (l2 >= 64'(PROB_W) * 65536) ? 0 : 64'(PROB_W) * 65536 - l2;
    v = (nl * 64'(LN2_Q16) * w + (64'd1 << 31)) >> 32;
    return (v > 64'(LOSS_MAX)) ? LOSS_MAX : v[LOSS_W-1:0];
  endfunction

  function automatic logic signed [GRAD_W-1:0] scaled_gradient(
      input longint p, input bit hot, input longint w);
    longint v, mag, g;
    v = w * (p - (hot ? 65536 : 0));
    mag = (v < 0) ? -v : v;
    mag = (mag + 128) >>> 8;
    g = (v < 0) ? -mag : mag;
    if (g > 16777215) g = 16777215;
    if (g < -16777216) g = -16777216;
    return g[GRAD_W-1:0];
  endfunction

  task automatic predict_txn(input logic op, input logic signed [SCORE_W-1:0] sc,
                             input logic lst, input logic [IDX_W-1:0] lbl,
                             input logic lv, input logic [IDX_W-1:0] idx);
    smce_result_t res;
    logic [63:0] sum, e, p, bestp;
    int unsigned best;
    res = '0;
    if (op == OP_LOAD) begin
      if (loaded_cnt < MAX_CLASSES) begin
        score_mem[loaded_cnt] = sc;
        loaded_cnt++;
        if (int'(sc) > peak_score) peak_score = int'(sc);
      end else begin
        overflow_q = 1'b1;
      end
      if (!lst) return;
      label_q = lbl;
      label_valid_q = lv;
      sum = 0;
      for (int i = 0; i < loaded_cnt; i++)
        sum += exp_weight(peak_score - int'(score_mem[i]));
      best = 0;
      bestp = 0;
      for (int i = 0; i < loaded_cnt; i++) begin
        e = exp_weight(peak_score - int'(score_mem[i]));
        p = (sum != 0) ? ((e << PROB_W) + sum / 2) / sum : 0;
        if (p > 65535) p = 65535;
        prob_mem[i] = p[PROB_W-1:0];
        if (i == 0 || p > bestp) begin
          bestp = p;
          best = i;
        end
      end
      ready_cnt = loaded_cnt;
      res.kind = KIND_SUMMARY;
      res.status = overflow_q ? ST_OVERFLOW : ST_OK;
      res.loss_valid = lv;
      if (lv)
        res.loss = neg_log_loss((lbl < ready_cnt) ? 64'(prob_mem[lbl]) : 0,
                                64'(weight_q));
      res.best_class = best[IDX_W-1:0];
      res.best_prob = bestp[PROB_W-1:0];
      loaded_cnt = 0;
      peak_score = -32768;
      overflow_q = 1'b0;
    end else begin
      res.kind = KIND_READOUT;
      if (idx >= ready_cnt) begin
        res.status = ST_RANGE;
      end else begin
        res.status = ST_OK;
        res.class_prob = prob_mem[idx];
        res.gradient = scaled_gradient(longint'(prob_mem[idx]),
                                       label_valid_q && idx == label_q,
                                       longint'(weight_q));
      end
    end
    expected_q.push_back(res);
  endtask

  task automatic send_txn(input logic op, input logic signed [SCORE_W-1:0] sc,
                          input logic lst, input logic [IDX_W-1:0] lbl,
                          input logic lv, input logic [IDX_W-1:0] idx);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    score <= sc;
    last <= lst;
    label <= lbl;
    label_valid <= lv;
    class_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_txn(op, sc, lst, lbl, lv, idx);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    go_idle();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic readout(input int idx);
    send_txn(OP_READ, SCORE_W'($urandom), 1'($urandom), IDX_W'($urandom),
             1'($urandom), idx[IDX_W-1:0]);
  endtask

  task automatic load_scores(input int n, input int base, input int spread,
                             input int lbl, input bit lv);
    int s;
    for (int i = 0; i < n; i++) begin
      s = base + $urandom_range(0, 2 * spread) - spread;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      send_txn(OP_LOAD, s[SCORE_W-1:0], i == n - 1,
               (i == n - 1) ? lbl[IDX_W-1:0] : IDX_W'($urandom),
               (i == n - 1) ? lv : 1'($urandom), IDX_W'($urandom));
    end
  endtask

  task automatic set_weight(input logic [WEIGHT_W-1:0] w);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
    weight_q = w;
  endtask

  task automatic test_before_sample();
    readout(0);
    readout(1023);
  endtask

  task automatic test_extremes();
    send_txn(OP_LOAD, 16'sh7FFF, 1'b0, '0, 1'b0, '0);
    send_txn(OP_LOAD, -16'sh8000, 1'b1, '0, 1'b1, '0);
    readout(0);
    readout(1);
    readout(2);
    send_txn(OP_LOAD, 16'sd0, 1'b1, '0, 1'b1, '0);
    readout(0);
    // tie: lowest index wins
    send_txn(OP_LOAD, 16'sd100, 1'b0, '0, 1'b0, '0);
    send_txn(OP_LOAD, 16'sd300, 1'b0, '0, 1'b0, '0);
    send_txn(OP_LOAD, 16'sd300, 1'b1, 10'd1, 1'b1, '0);
    readout(1);
    readout(2);
  endtask

  task automatic test_labels();
    load_scores(3, 0, 400, 1023, 1'b1);
    readout(2);
    load_scores(4, -500, 300, 2, 1'b0);
    readout(2);
    readout(3);
    send_txn(OP_LOAD, 16'sd50, 1'b0, '0, 1'b0, '0);
    readout(1);
    send_txn(OP_LOAD, 16'sd60, 1'b1, 10'd0, 1'b1, '0);
  endtask

  task automatic test_weights();
    set_weight(16'd0);
    load_scores(3, 0, 300, 1, 1'b1);
    readout(1);
    set_weight(16'hFFFF);
    load_scores(3, 0, 300, 0, 1'b1);
    readout(0);
    readout(2);
    set_weight(WEIGHT_RESET);
  endtask

  task automatic test_overflow();
    tx_calm = 1;
    load_scores(MAX_CLASSES + 2, 0, 2000, 700, 1'b1);
    tx_calm = 0;
    readout(1023);
    readout(700);
  endtask

  task automatic test_pressure();
    load_scores(2, 0, 200, 0, 1'b1);
    wait_drain();
    hold_req = 1;
    for (int i = 0; i < 16; i++) readout($urandom_range(0, 2));
    wait_drain();
  endtask

  task automatic test_random();
    int n, lbl;
    while (sent_items < 1850) begin
      tx_calm = ($urandom_range(0, 7) == 0);
      rx_calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) set_weight(WEIGHT_W'($urandom));
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      lbl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
      if ($urandom_range(0, 5) == 0) readout($urandom_range(0, 1023));
      if ($urandom_range(0, 3) == 0)
        load_scores(n, $urandom_range(0, 65535) - 32768, 32767, lbl,
                    $urandom_range(0, 4) != 0);
      else
        load_scores(n, $urandom_range(0, 4000) - 2000, $urandom_range(0, 1500), lbl,
                    $urandom_range(0, 4) != 0);
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 7) == 0) readout($urandom_range(0, 1023));
        else readout($urandom_range(0, n + 1));
      end
    end
    tx_calm = 0;
    rx_calm = 0;
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    smce_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{kind, status, loss, loss_valid, best_class, best_prob,
              class_prob, gradient};
      rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got.kind !== want.kind || got.status !== want.status ||
            got.loss !== want.loss || got.loss_valid !== want.loss_valid ||
            got.best_class !== want.best_class || got.best_prob !== want.best_prob ||
            got.class_prob !== want.class_prob || got.gradient !== want.gradient) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_before_sample();
    test_extremes();
    test_labels();
    test_weights();
    test_pressure();
    test_overflow();
    test_random();
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
